// ===== src/lcet_pkg.sv =====
// ============================================================================
// lcet_pkg
// Shared types and constants for the line contrast edge timer.
// ============================================================================
package lcet_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int PERIOD_W    = 10;
    localparam int TIME_W      = 32;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD    = 8'd1;

    localparam logic [SAMPLE_W-1:0] THRESH_RESET = 12'd4050;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd25;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_INIT,
        ST_DIV,
        ST_DECIDE
    } lcet_state_t;

    typedef struct packed {
        logic load;      // accept sample, update ring and sum
        logic div_init;  // seed divider with current sum
        logic div_step;  // one restoring divide step
        logic emit;      // capture result, clear timer, flip surface
        logic tick;      // advance surface timer
    } lcet_cmd_t;

    typedef struct packed {
        logic transition;
    } lcet_status_t;

endpackage

// ===== src/line_contrast_edge_timer.sv =====
// ============================================================================
// line_contrast_edge_timer
// Windowed-average surface transition timer for a line sensor.
// ============================================================================
// Sequence: from the accepting edge the block seeds the divider, runs SUM_W
//   serial divide steps and decides; DECIDE holds a transition while the
//   previous result is unaccepted. A new sample is taken only in IDLE, once
//   the restoring divider, producing one quotient bit per cycle, is done.
// Reset: aresetn synchronous active low; clears the ring, sum, timer, result
//   valid, sets the surface to black and loads the default register values.
// ============================================================================
module line_contrast_edge_timer
    import lcet_pkg::*;
#(
    parameter int WINDOW = 3
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // sample input channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_W-1:0]    s_sample,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_left_black,
    output logic [TIME_W-1:0]      m_duration_ms,
    output logic [SAMPLE_W-1:0]    m_average_level,
    // configuration write channel; always ready
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Sum of WINDOW 12-bit samples needs log2(WINDOW) extra bits.
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);

    lcet_cmd_t    cmd;
    lcet_status_t status;

    // Register writes are always accepted; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    // Controller: IDLE takes a sample transaction, then seeds the divider,
    // runs SUM_W divide steps and decides. A transition waits in DECIDE only
    // while a previous result still sits unaccepted in the output register,
    // so a new sample may be taken while an older result is pending.
    lcet_ctrl #(
        .SUM_W (SUM_W)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // Datapath: ring of samples, running sum, average = floor(sum / fill),
    // threshold compare against the surface flag, saturating timer.
    lcet_datapath #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_sample        (s_sample),
        .cfg_write       (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_left_black    (m_left_black),
        .m_duration_ms   (m_duration_ms),
        .m_average_level (m_average_level)
    );

endmodule

// ===== src/lcet_ctrl.sv =====
// ============================================================================
// lcet_ctrl
// Sequencer: sample load, serial divide, decide/emit, result valid.
// ============================================================================
module lcet_ctrl
    import lcet_pkg::*;
#(
    parameter int SUM_W = 14
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    output lcet_cmd_t    cmd,
    input  lcet_status_t status
);

    localparam int ITER_W = $clog2(SUM_W);

    lcet_state_t       state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_free;

    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            iter_reg    <= iter_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                iter_next    = ITER_W'(SUM_W - 1);
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                iter_next    = iter_reg - 1'b1;
                if (iter_reg == '0) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (status.transition) begin
                    if (out_free) begin
                        cmd.emit   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.tick   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

endmodule

// ===== src/lcet_datapath.sv =====
// ============================================================================
// lcet_datapath
// Sample ring, running sum, serial divider, surface timer, config registers.
// ============================================================================
module lcet_datapath
    import lcet_pkg::*;
#(
    parameter int WINDOW = 3,
    parameter int SUM_W  = 14
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lcet_cmd_t              cmd,
    output lcet_status_t           status,
    input  logic [SAMPLE_W-1:0]    s_sample,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   m_left_black,
    output logic [TIME_W-1:0]      m_duration_ms,
    output logic [SAMPLE_W-1:0]    m_average_level
);

    localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int REM_W = CNT_W + 1;

    logic [SAMPLE_W-1:0] ring_reg [WINDOW];
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SUM_W-1:0]    quot_reg, quot_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic                on_black_reg;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [SAMPLE_W-1:0] thr_reg;
    logic [PERIOD_W-1:0] per_reg;
    logic                left_black_reg;
    logic [TIME_W-1:0]   duration_reg;
    logic [SAMPLE_W-1:0] average_reg;

    logic [SAMPLE_W-1:0] old_sample;
    logic [REM_W-1:0]    shifted, fill_ext;
    logic [SAMPLE_W-1:0] avg;
    logic [TIME_W:0]     time_sum;

    assign m_left_black    = left_black_reg;
    assign m_duration_ms   = duration_reg;
    assign m_average_level = average_reg;

    // ring update and running sum
    always_comb begin
        old_sample = ring_reg[pos_reg];
        sum_next   = sum_reg - SUM_W'(old_sample) + SUM_W'(s_sample);
        if (pos_reg == POS_W'(WINDOW - 1)) begin
            pos_next = '0;
        end else begin
            pos_next = pos_reg + 1'b1;
        end
        if (fill_reg == CNT_W'(WINDOW)) begin
            fill_next = fill_reg;
        end else begin
            fill_next = fill_reg + 1'b1;
        end
    end

    // restoring divide step, one quotient bit per cycle
    always_comb begin
        shifted  = {rem_reg[REM_W-2:0], quot_reg[SUM_W-1]};
        fill_ext = REM_W'(fill_reg);
        if (shifted >= fill_ext) begin
            rem_next  = shifted - fill_ext;
            quot_next = {quot_reg[SUM_W-2:0], 1'b1};
        end else begin
            rem_next  = shifted;
            quot_next = {quot_reg[SUM_W-2:0], 1'b0};
        end
    end

    assign avg = quot_reg[SAMPLE_W-1:0];
    assign status.transition = on_black_reg ? (avg <= thr_reg) : (avg > thr_reg);

    // saturating timer
    always_comb begin
        time_sum = {1'b0, time_reg} + (TIME_W + 1)'(per_reg);
        if (time_sum[TIME_W]) begin
            time_next = '1;
        end else begin
            time_next = time_sum[TIME_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) begin
                ring_reg[i] <= '0;
            end
            pos_reg      <= '0;
            fill_reg     <= '0;
            sum_reg      <= '0;
            on_black_reg <= 1'b1;
            time_reg     <= '0;
            thr_reg      <= THRESH_RESET;
            per_reg      <= PERIOD_RESET;
        end else begin
            if (cmd.load) begin
                ring_reg[pos_reg] <= s_sample;
                pos_reg           <= pos_next;
                fill_reg          <= fill_next;
                sum_reg           <= sum_next;
            end
            if (cmd.emit) begin
                time_reg     <= '0;
                on_black_reg <= !on_black_reg;
            end else if (cmd.tick) begin
                time_reg <= time_next;
            end
            if (cfg_write) begin
                case (cfg_index)
                    CFG_THRESHOLD: thr_reg <= cfg_data[SAMPLE_W-1:0];
                    CFG_PERIOD:    per_reg <= cfg_data[PERIOD_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // divider and result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            quot_reg <= sum_reg;
            rem_reg  <= '0;
        end else if (cmd.div_step) begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
        if (cmd.emit) begin
            left_black_reg <= on_black_reg;
            duration_reg   <= time_reg;
            average_reg    <= avg;
        end
    end

endmodule

// ===== bench/lcet_crossing_monitor.sv =====
// ============================================================================
// lcet_crossing_monitor
// Watches the sample, result and register write channels of the line
// contrast edge timer. Keeps its own copy of the window, the surface flag and
// the surface timer, predicts every surface crossing and compares each result
// transaction with the oldest prediction.
// ============================================================================
module lcet_crossing_monitor
    import lcet_pkg::*;
#(
    parameter int WINDOW = 3
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [SAMPLE_W-1:0]    s_sample,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic                   m_left_black,
    input  logic [TIME_W-1:0]      m_duration_ms,
    input  logic [SAMPLE_W-1:0]    m_average_level,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     pending,
    output int                     crossings_checked
);

    localparam int SUM_W = $clog2((2**SAMPLE_W - 1) * WINDOW + 1);

    typedef struct packed {
        logic                left_black;
        logic [TIME_W-1:0]   duration_ms;
        logic [SAMPLE_W-1:0] average_level;
    } crossing_t;

    logic [SAMPLE_W-1:0] threshold;
    logic [PERIOD_W-1:0] period;
    logic [SAMPLE_W-1:0] ring [WINDOW];
    logic [SUM_W-1:0]    ring_total;
    int                  ring_pos;
    int                  fill;
    logic                on_black;
    logic [TIME_W-1:0]   surface_timer;

    crossing_t crossings_due [$];
    int        fail_count = 0;
    int        good_count = 0;

    // One sample through the window; queues a crossing when the average
    // lands on the other side of the threshold.
    task automatic predict_crossing(input logic [SAMPLE_W-1:0] smp);
        crossing_t           c;
        logic [SAMPLE_W-1:0] avg;
        ring_total     = ring_total - ring[ring_pos] + smp;
        ring[ring_pos] = smp;
        ring_pos       = (ring_pos == WINDOW - 1) ? 0 : ring_pos + 1;
        if (fill < WINDOW)
            fill++;
        avg = SAMPLE_W'(ring_total / fill);
        if (on_black == (avg <= threshold)) begin
            c.left_black    = on_black;
            c.duration_ms   = surface_timer;
            c.average_level = avg;
            crossings_due.push_back(c);
            surface_timer = '0;
            on_black      = !on_black;
        end else if ({1'b0, surface_timer} + period > {1'b0, {TIME_W{1'b1}}}) begin
            surface_timer = '1;
        end else begin
            surface_timer = surface_timer + period;
        end
    endtask

    always @(posedge aclk) begin : watch
        crossing_t want;
        if (!aresetn) begin
            threshold     = THRESH_RESET;
            period        = PERIOD_RESET;
            ring_total    = '0;
            ring_pos      = 0;
            fill          = 0;
            on_black      = 1'b1;
            surface_timer = '0;
            for (int i = 0; i < WINDOW; i++)
                ring[i] = '0;
            crossings_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (crossings_due.size() == 0) begin
                    $display("%0t: result with none expected: left_black %0d duration %0d level %0d",
                             $time, m_left_black, m_duration_ms, m_average_level);
                    fail_count++;
                end else begin
                    want = crossings_due.pop_front();
                    if (m_left_black !== want.left_black) begin
                        $display("%0t: left_black expected %0d got %0d",
                                 $time, want.left_black, m_left_black);
                        fail_count++;
                    end
                    if (m_duration_ms !== want.duration_ms) begin
                        $display("%0t: duration_ms expected %0d got %0d",
                                 $time, want.duration_ms, m_duration_ms);
                        fail_count++;
                    end
                    if (m_average_level !== want.average_level) begin
                        $display("%0t: average_level expected %0d got %0d",
                                 $time, want.average_level, m_average_level);
                        fail_count++;
                    end
                    good_count++;
                end
            end
            if (s_valid && s_ready)
                predict_crossing(s_sample);
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_THRESHOLD)
                    threshold = cfg_data[SAMPLE_W-1:0];
                else if (cfg_index == CFG_PERIOD)
                    period = cfg_data[PERIOD_W-1:0];
            end
        end
        mismatches        <= fail_count;
        pending           <= crossings_due.size();
        crossings_checked <= good_count;
    end

endmodule

// ===== bench/tb_line_contrast_edge_timer.sv =====
// ============================================================================
// tb_line_contrast_edge_timer
// Drives reflectance samples and register writes into the line contrast edge
// timer with random pacing on both channels; a crossing monitor predicts and
// checks every result transaction.
// ============================================================================
module tb_line_contrast_edge_timer;
    import lcet_pkg::*;

    localparam int WINDOW = 3;
    localparam int ITEMS  = 1350;
    localparam int DRAIN  = 40;    // outlasts the block's handling of one sample
    localparam int MAX_GAP = 17;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [SAMPLE_W-1:0]    s_sample;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_left_black;
    logic [TIME_W-1:0]      m_duration_ms;
    logic [SAMPLE_W-1:0]    m_average_level;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int mismatches;
    int pending;
    int crossings_checked;

    // Pacing knobs: when set, that side runs back to back for the phase.
    logic s_steady = 1'b0;
    logic m_steady = 1'b0;

    int samples_sent = 0;
    int reg_writes   = 0;
    logic [SAMPLE_W-1:0] thr_now = THRESH_RESET;  // shapes the stimulus only

    always #5 aclk = ~aclk;

    line_contrast_edge_timer #(
        .WINDOW(WINDOW)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_black   (m_left_black),
        .m_duration_ms  (m_duration_ms),
        .m_average_level(m_average_level),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    lcet_crossing_monitor #(
        .WINDOW(WINDOW)
    ) crossing_monitor (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_left_black     (m_left_black),
        .m_duration_ms    (m_duration_ms),
        .m_average_level  (m_average_level),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .pending          (pending),
        .crossings_checked(crossings_checked)
    );

    // ------------------------------------------------------------------------
    // Sample channel: random gap before each transaction, then valid is held
    // with a stable payload until the edge where ready is also high. Valid is
    // dropped only for a gap or an idle wait; back-to-back items keep it high.
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        int gap;
        gap = s_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= smp;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
    endtask

    // Register write; ends the cycle after the transaction, cfg_valid low, so
    // that the next write never lowers and raises cfg_valid in the same step.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_THRESHOLD)
            thr_now = data[SAMPLE_W-1:0];
        reg_writes++;
    endtask

    // Registers change only with the block idle: every predicted crossing
    // delivered, then a pause for a sample that produced no result.
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN) @(posedge aclk);
    endtask

    // A sample on the requested side of the current threshold, or full scale when nothing can read as black.
    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic want_black);
        if (want_black)
            return (thr_now == '1) ? '1 : SAMPLE_W'($urandom_range(thr_now + 1, 4095));
        return SAMPLE_W'($urandom_range(0, thr_now));
    endfunction

    // ------------------------------------------------------------------------
    // Result channel: random stall before each transaction, ready then held
    // until a result is taken.
    // ------------------------------------------------------------------------
    initial begin : result_pacing
        int stall;
        m_ready = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = m_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int   phase_len;
        int   run_left;
        int   phase;
        logic want_black;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_sample  = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values: drop to white on the first sample, climb back to
        // black once the window fills with full-scale readings.
        send_sample('0);
        send_sample('1);
        send_sample('1);
        send_sample('1);
        send_sample('1);
        send_sample(12'hAAA);
        send_sample(12'h555);

        // Threshold at full scale through a write with the upper data bits
        // set; nothing can read as black. Tick period of 1000.
        wait_idle();
        write_reg(CFG_THRESHOLD, 16'hFFFF);
        write_reg(CFG_PERIOD, 16'd1000);
        send_sample('1);
        send_sample('1);
        send_sample('1);

        // Threshold zero, tick period zero: timer holds while on a surface.
        wait_idle();
        write_reg(CFG_THRESHOLD, 16'd0);
        write_reg(CFG_PERIOD, 16'd0);
        send_sample('0);
        send_sample('0);
        send_sample(12'd1);
        send_sample('1);
        send_sample('0);

        // Oversized period keeps its low bits (1023); writes past the
        // register list must not disturb the threshold.
        wait_idle();
        write_reg(CFG_PERIOD, 16'hFFFF);
        write_reg(CFG_THRESHOLD, 16'd2048);
        write_reg(CFG_PERIOD + 1'b1, 16'd0);
        write_reg('1, 16'd0);
        send_sample(12'd2047);
        send_sample(12'd2048);
        send_sample(12'd2049);
        send_sample('1);
        send_sample('1);
        send_sample('0);
        send_sample('0);
        send_sample('0);

        wait_idle();
        write_reg(CFG_PERIOD, 16'd1);
        send_sample('1);
        send_sample('0);

        // Random phases: new register values each time, runs of samples on
        // alternating sides of the threshold so crossings keep coming, with
        // some uniform noise mixed in.
        phase      = 0;
        want_black = 1'b0;
        run_left   = 0;
        while (samples_sent < ITEMS) begin
            wait_idle();
            case (phase % 4)
                0:       data = CFG_DATA_W'(0);
                1:       data = CFG_DATA_W'(4095);
                default: data = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
            endcase
            write_reg(CFG_THRESHOLD, data);
            case ($urandom_range(0, 4))
                0:       data = CFG_DATA_W'(0);
                1:       data = CFG_DATA_W'(1);
                2:       data = CFG_DATA_W'(1023);
                default: data = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
            endcase
            write_reg(CFG_PERIOD, data);
            // Stray write to any index, so every index and data bit moves.
            if ($urandom_range(0, 2) == 0) begin
                idx  = CFG_INDEX_W'($urandom_range(0, 255));
                data = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
                write_reg(idx, data);
            end
            s_steady  = ($urandom_range(0, 3) == 0);
            m_steady  = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(60, 140);
            for (int i = 0; i < phase_len && samples_sent < ITEMS; i++) begin
                if (run_left == 0) begin
                    want_black = !want_black;
                    run_left   = $urandom_range(1, 12);
                end
                run_left--;
                if ($urandom_range(0, 5) == 0)
                    send_sample(SAMPLE_W'($urandom_range(0, 4095)));
                else
                    send_sample(pick_sample(want_black));
            end
            phase++;
        end

        // Final drain: every crossing delivered, then a quiet stretch in
        // which any stray result would be flagged by the monitor.
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN) @(posedge aclk);

        $display("Run covered %0d samples and %0d register writes over %0d random phases,",
                 samples_sent, reg_writes, phase);
        $display("with %0d surface crossings checked against the prediction.",
                 crossings_checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin : watchdog
        #5000000;
        $display("Timeout after %0t with %0d crossings outstanding", $time, pending);
        $display("Mismatches found");
        $finish;
    end

endmodule
